// ----- sv/tvbs_pkg.sv -----
// ----------------------------------------------------------------------------
// tvbs_pkg: shared types and helpers for the typed value byte serializer
// Command codes, controller/datapath link structs and the value preparation
// functions (zigzag mapping and byte reversal).
// ----------------------------------------------------------------------------
package tvbs_pkg;

	localparam logic [3:0] CMD_U8     = 4'd0;
	localparam logic [3:0] CMD_U16    = 4'd1;
	localparam logic [3:0] CMD_U24    = 4'd2;
	localparam logic [3:0] CMD_U32    = 4'd3;
	localparam logic [3:0] CMD_U64    = 4'd4;
	localparam logic [3:0] CMD_VAR32  = 4'd5;
	localparam logic [3:0] CMD_VAR64  = 4'd6;
	localparam logic [3:0] CMD_ZZ32   = 4'd7;
	localparam logic [3:0] CMD_ZZ64   = 4'd8;
	localparam logic [3:0] CMD_U32BE  = 4'd9;

	localparam logic [7:0] GROUP_MASK = 8'h7F;
	localparam logic [7:0] CONT_BIT   = 8'h80;
	localparam logic [7:0] BYTE_MASK  = 8'hFF;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} tvbs_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;     // capture and prepare the incoming item
		logic advance;  // current byte was taken, step to the next one
	} tvbs_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic cmd_ok;   // incoming command is a defined one
		logic last;     // current byte is the final byte of the item
	} tvbs_status_t;

	// Reverses the order of the low n bytes of v; bytes above n come out zero.
	function automatic logic [63:0] swap_bytes(input logic [63:0] v, input logic [3:0] n);
		logic [63:0] r;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			for (int j = 0; j < 8; j++) begin
				if ((i + j) == (int'(n) - 1)) begin
					r[8*i +: 8] = v[8*j +: 8];
				end
			end
		end
		return r;
	endfunction

	function automatic logic [31:0] zigzag32(input logic [31:0] w);
		return w[31] ? {~w[30:0], 1'b1} : {w[30:0], 1'b0};
	endfunction

	function automatic logic [63:0] zigzag64(input logic [63:0] w);
		return w[63] ? {~w[62:0], 1'b1} : {w[62:0], 1'b0};
	endfunction

endpackage

// ----- sv/tvbs_dp.sv -----
// ----------------------------------------------------------------------------
// tvbs_dp: serializer datapath
// Holds the byte order register, the prepared value as a shift register and
// the fixed-width byte counter, and forms the current output byte.
// ----------------------------------------------------------------------------
module tvbs_dp import tvbs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	input  logic [3:0]   cmd,
	input  logic [63:0]  value,
	input  tvbs_cmd_t    ctl,
	output tvbs_status_t sts,
	output logic [7:0]   byte_out
);

	logic        big_endian_q;
	logic [63:0] sh_q;
	logic [2:0]  cnt_q;
	logic        varint_q;

	logic [63:0] prep;
	logic [2:0]  prep_cnt;
	logic        prep_varint;
	logic        cmd_ok;

	// Value preparation: masking, zigzag mapping and byte reversal.
	always_comb begin
		prep        = '0;
		prep_cnt    = '0;
		prep_varint = 1'b0;
		cmd_ok      = 1'b1;
		case (cmd)
			CMD_U8: begin
				prep     = {56'd0, value[7:0]};
				prep_cnt = 3'd0;
			end
			CMD_U16: begin
				prep     = big_endian_q ? swap_bytes(value, 4'd2) : {48'd0, value[15:0]};
				prep_cnt = 3'd1;
			end
			CMD_U24: begin
				prep     = big_endian_q ? swap_bytes(value, 4'd3) : {40'd0, value[23:0]};
				prep_cnt = 3'd2;
			end
			CMD_U32: begin
				prep     = big_endian_q ? swap_bytes(value, 4'd4) : {32'd0, value[31:0]};
				prep_cnt = 3'd3;
			end
			CMD_U64: begin
				prep     = big_endian_q ? swap_bytes(value, 4'd8) : value;
				prep_cnt = 3'd7;
			end
			CMD_U32BE: begin
				prep     = swap_bytes(value, 4'd4);
				prep_cnt = 3'd3;
			end
			CMD_VAR32: begin
				prep        = big_endian_q ? swap_bytes(value, 4'd4) : {32'd0, value[31:0]};
				prep_varint = 1'b1;
			end
			CMD_VAR64: begin
				prep        = big_endian_q ? swap_bytes(value, 4'd8) : value;
				prep_varint = 1'b1;
			end
			CMD_ZZ32: begin
				prep        = big_endian_q ? swap_bytes({32'd0, zigzag32(value[31:0])}, 4'd4)
					: {32'd0, zigzag32(value[31:0])};
				prep_varint = 1'b1;
			end
			CMD_ZZ64: begin
				prep        = big_endian_q ? swap_bytes(zigzag64(value), 4'd8) : zigzag64(value);
				prep_varint = 1'b1;
			end
			default: begin
				cmd_ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b0;
		end else if (cfg_we) begin
			big_endian_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			varint_q <= 1'b0;
		end else if (ctl.load) begin
			cnt_q    <= prep_cnt;
			varint_q <= prep_varint;
		end else if (ctl.advance && !varint_q) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sh_q <= prep;
		end else if (ctl.advance) begin
			sh_q <= varint_q ? {7'd0, sh_q[63:7]} : {8'd0, sh_q[63:8]};
		end
	end

	logic more_groups;
	assign more_groups = |sh_q[63:7];

	always_comb begin
		if (varint_q) begin
			byte_out = (sh_q[7:0] & GROUP_MASK) | (more_groups ? CONT_BIT : 8'h00);
		end else begin
			byte_out = sh_q[7:0] & BYTE_MASK;
		end
	end

	assign sts.cmd_ok = cmd_ok;
	assign sts.last   = varint_q ? !more_groups : (cnt_q == 3'd0);

endmodule

// ----- sv/tvbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// tvbs_ctrl: serializer controller
// Two-state machine that takes one item while idle and, for a defined command,
// then presents its bytes one transaction at a time until the final byte is taken.
// ----------------------------------------------------------------------------
module tvbs_ctrl import tvbs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	output logic         m_tvalid,
	input  logic         m_tready,
	input  tvbs_status_t sts,
	output tvbs_cmd_t    ctl
);

	tvbs_state_t state_q, state_d;

	assign s_tready    = (state_q == ST_IDLE);
	assign m_tvalid    = (state_q == ST_EMIT);
	assign ctl.load    = s_tvalid && s_tready && sts.cmd_ok;
	assign ctl.advance = m_tvalid && m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (ctl.load) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (ctl.advance && sts.last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- sv/typed_value_byte_serializer_core.sv -----
// ----------------------------------------------------------------------------
// typed_value_byte_serializer_core: typed value to byte stream serializer
// Encodes fixed-width integers, LEB128 varints and zigzag varints into a
// stream of bytes with the final byte of each item marked.
// ----------------------------------------------------------------------------
// Each input transaction carries a command on tuser and a 64-bit value on
// tdata; the block then sends one output transaction per serialized byte,
// with tlast on the final one. Items are handled one at a time: a new item
// is taken only after the final byte of the last one is taken. An item has
// N bytes, with N from 1 to 10 (a 64-bit varint of a value using bit 63 is
// the ten-byte case). The value shift register moves on by one byte, or by
// one seven-bit group for varints, per output transaction. Commands 10 to 15
// are accepted and dropped without output. The big_endian register is written
// through cfg_we/cfg_wdata; the user must write it only while no item is in
// flight, and the block does not enforce this. It reverses byte order for the
// fixed-width commands and reverses the bytes of the value before varint
// coding, while command 9 is always written most significant byte first.
module typed_value_byte_serializer_core import tvbs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,     // big_endian
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [3:0]  s_tuser,       // [3:0] cmd
	input  logic [63:0] s_tdata,       // [63:0] value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,       // [7:0] byte_out
	output logic        m_tlast        // last
);

	tvbs_cmd_t    ctl;
	tvbs_status_t sts;

	// The controller owns the handshakes; the datapath owns all payload.
	tvbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	tvbs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (s_tuser),
		.value     (s_tdata),
		.ctl       (ctl),
		.sts       (sts),
		.byte_out  (m_tdata)
	);

	// The final-byte flag is only meaningful while a byte is presented.
	assign m_tlast = sts.last;

endmodule

// ----- sv/tvbs_checker.sv -----
// ----------------------------------------------------------------------------
// tvbs_checker: port-level checks for the serializer
// Watches the top-level ports and flags ordering and handshake slips.
// ----------------------------------------------------------------------------
module tvbs_checker import tvbs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [3:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast
);

	// Input is only taken when no byte is pending.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("input ready while bytes are pending");

	// A single-byte item presents exactly one marked byte next cycle.
	a_u8_single: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == CMD_U8) |=> (m_tvalid && m_tlast))
		else $error("u8 item did not produce a single final byte");

	// An unused command leaves the block ready for the next item.
	a_drop_unused: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser > CMD_U32BE) |=> (s_tready && !m_tvalid))
		else $error("unused command produced output");

	// A stalled byte holds its value and marker.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("stalled output byte changed");

endmodule

bind typed_value_byte_serializer_core tvbs_checker u_tvbs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ----- tb/sv/typed_value_byte_serializer_core_tb.sv -----
// ----------------------------------------------------------------------------
// typed_value_byte_serializer_core_tb: self-checking regression for the
// typed value byte serializer core
// Drives typed values into the slave stream and checks every serialized byte
// on the master stream against a cycle-free predictor of the encoding, for
// both byte orders, with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module typed_value_byte_serializer_core_tb;
	import tvbs_pkg::*;

	// Cycles allowed after the last expected byte before the block counts as idle.
	// This leaves ample margin over the longest item.
	localparam int DRAIN_CYCLES = 16;
	// Watchdog.
	localparam int CYCLE_LIMIT = 200000;
	// Idle chance in percent: per cycle on the sink side, per item on the source side.
	localparam int IDLE_PCT = 6;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} ser_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [3:0]  s_tuser = '0;      // [3:0] cmd
	logic [63:0] s_tdata = '0;      // [63:0] value
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;           // [7:0] byte_out
	logic        m_tlast;

	// Bytes the encoder still owes us, oldest first.
	ser_byte_t pending_bytes[$];
	// Our copy of the big_endian register.
	logic      byte_order_be = 1'b0;
	// When set, neither side inserts idle cycles.
	bit        stall_free = 1'b0;
	int        error_count = 0;
	int        cycle_count = 0;

	typed_value_byte_serializer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("typed_value_byte_serializer_core regression: fail");
			$finish;
		end
	end

	// The sink drops tready now and then, except during the stall-free stretch.
	always @(posedge clk) begin
		m_tready <= stall_free || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Reverses the low nb bytes of v; everything above comes out zero.
	function automatic logic [63:0] byte_reverse(input logic [63:0] v, input int nb);
		logic [63:0] r;
		r = '0;
		for (int i = 0; i < nb; i++) begin
			r = (r << 8) | 64'(v[8*i +: 8]);
		end
		return r;
	endfunction

	// Fixed-width write of nb bytes, in either order; only the last is marked.
	function automatic void push_fixed(input logic [63:0] v, input int nb, input bit msb_first);
		int sh;
		for (int i = 0; i < nb; i++) begin
			sh = msb_first ? (nb - 1 - i) * 8 : i * 8;
			pending_bytes.push_back('{data: v[sh +: 8], last: (i == nb - 1)});
		end
	endfunction

	// LEB128: seven bits per byte, low group first, bit 7 flags more to come.
	// Zero still yields one byte.
	function automatic void push_varint(input logic [63:0] u);
		logic [63:0] rest;
		logic [7:0]  b;
		rest = u;
		do begin
			b = {1'b0, rest[6:0]};
			rest = rest >> 7;
			if (rest != 0) b = b | CONT_BIT;
			pending_bytes.push_back('{data: b, last: (rest == 0)});
		end while (rest != 0);
	endfunction

	// Zigzag maps small magnitudes of either sign to small codes:
	// a sign-extended XOR of the shifted value gives (v << 1) for v >= 0
	// and (~v << 1) | 1 otherwise.
	function automatic logic [31:0] zz_map32(input logic [31:0] w);
		return {w[30:0], 1'b0} ^ {32{w[31]}};
	endfunction

	function automatic logic [63:0] zz_map64(input logic [63:0] w);
		return {w[62:0], 1'b0} ^ {64{w[63]}};
	endfunction

	// Appends the bytes that one accepted item must produce. In big-endian
	// mode the varint commands reverse the value's bytes before coding,
	// which is what the block is meant to do even if it looks odd.
	function automatic void encode_item(input logic [3:0] cmd, input logic [63:0] val);
		logic [63:0] u;
		case (cmd)
			CMD_U8:    push_fixed({56'd0, val[7:0]}, 1, byte_order_be);
			CMD_U16:   push_fixed({48'd0, val[15:0]}, 2, byte_order_be);
			CMD_U24:   push_fixed({40'd0, val[23:0]}, 3, byte_order_be);
			CMD_U32:   push_fixed({32'd0, val[31:0]}, 4, byte_order_be);
			CMD_U64:   push_fixed(val, 8, byte_order_be);
			CMD_VAR32: begin
				u = {32'd0, val[31:0]};
				if (byte_order_be) u = byte_reverse(u, 4);
				push_varint(u);
			end
			CMD_VAR64: begin
				u = val;
				if (byte_order_be) u = byte_reverse(u, 8);
				push_varint(u);
			end
			CMD_ZZ32: begin
				u = {32'd0, zz_map32(val[31:0])};
				if (byte_order_be) u = byte_reverse(u, 4);
				push_varint(u);
			end
			CMD_ZZ64: begin
				u = zz_map64(val);
				if (byte_order_be) u = byte_reverse(u, 8);
				push_varint(u);
			end
			CMD_U32BE: push_fixed({32'd0, val[31:0]}, 4, 1'b1);
			default: ;  // undefined commands are swallowed without output
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Output checker: every master transaction is matched against the
	// oldest expected byte. Inputs are sampled right after the edge, where
	// the nonblocking updates of that edge are not yet visible.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		ser_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h last=%0b", m_tdata, m_tlast));
			end else begin
				want = pending_bytes.pop_front();
				if (m_tdata !== want.data || m_tlast !== want.last) begin
					report_mismatch($sformatf("byte %02h last=%0b, expected %02h last=%0b",
						m_tdata, m_tlast, want.data, want.last));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Offers one item on the slave side and returns at the edge where the
	// transaction completes. tvalid is left high so back-to-back items keep
	// the bus busy; whoever stops sending lowers it.
	task automatic send_item(input logic [3:0] cmd, input logic [63:0] val);
		if (!stall_free && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= val;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		encode_item(cmd, val);
	endtask

	// Stops sending and waits until every expected byte has arrived, then waits
	// out the drain margin in case the block is still chewing on a dropped item.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register write; only done while nothing is in flight.
	task automatic set_byte_order(input logic be);
		wait_idle();
		cfg_wdata <= be;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we        <= 1'b0;
		byte_order_be = be;
	endtask

	// Values spread over many magnitudes so that varints of every length
	// appear, including small negatives for the zigzag forms.
	function automatic logic [63:0] rand_value();
		logic [63:0] v;
		v = {$urandom(), $urandom()};
		case ($urandom_range(0, 3))
			0: ;
			1: v = v >> $urandom_range(1, 63);
			2: v = ~(v >> $urandom_range(1, 63));
			default: v = v >> 56;
		endcase
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// All fixed-width commands in both byte orders. Bits above each width are
	// set so that masking is exercised; the always-big-endian word must not
	// follow the register.
	task automatic test_fixed_widths();
		for (int be = 0; be < 2; be++) begin
			set_byte_order(be[0]);
			send_item(CMD_U8,    64'hFFFF_FFFF_FFFF_FF00);
			send_item(CMD_U16,   64'hFFFF_FFFF_FFFF_A5C3);
			send_item(CMD_U24,   64'hFFFF_FFFF_FF12_3456);
			send_item(CMD_U32,   64'hDEAD_BEEF_8765_4321);
			send_item(CMD_U64,   64'h0123_4567_89AB_CDEF);
			send_item(CMD_U32BE, 64'hFFFF_FFFF_CAFE_F00D);
		end
	endtask

	// Varint and zigzag extremes: the one-byte zero, the five-byte 32-bit
	// maximum, the ten-byte 64-bit case, and the most negative and most
	// positive zigzag inputs; then a few in big-endian mode.
	task automatic test_varints();
		set_byte_order(1'b0);
		send_item(CMD_VAR64, 64'h0);
		send_item(CMD_VAR32, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(CMD_VAR64, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(CMD_ZZ32,  64'h0000_0000_8000_0000);
		send_item(CMD_ZZ64,  64'h7FFF_FFFF_FFFF_FFFF);
		set_byte_order(1'b1);
		send_item(CMD_VAR64, 64'h0000_0000_0000_0080);
		send_item(CMD_ZZ32,  64'hFFFF_FFFF_FFFF_FFFF);
	endtask

	// Undefined commands produce nothing; the checker flags any stray byte.
	task automatic test_unused_commands();
		for (int c = int'(CMD_U32BE) + 1; c < 16; c++) begin
			send_item(c[3:0], {$urandom(), $urandom()});
		end
		wait_idle();
	endtask

	// Random traffic in three phases: random byte order, big-endian, and a
	// stretch without any idle cycles on either side.
	task automatic test_random_stream();
		int          defined_items;
		logic [3:0]  cmd;
		for (int phase = 0; phase < 3; phase++) begin
			set_byte_order(phase == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
			stall_free    = (phase == 2);
			defined_items = 0;
			while (defined_items < 24) begin
				if ($urandom_range(0, 99) < 10) begin
					cmd = 4'($urandom_range(int'(CMD_U32BE) + 1, 15));
				end else begin
					cmd = 4'($urandom_range(int'(CMD_U8), int'(CMD_U32BE)));
					defined_items++;
				end
				send_item(cmd, rand_value());
			end
		end
		wait_idle();
		stall_free = 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fixed_widths();
		test_varints();
		test_unused_commands();
		test_random_stream();

		if (error_count == 0) begin
			$display("typed_value_byte_serializer_core regression: pass");
		end else begin
			$display("typed_value_byte_serializer_core regression: fail");
		end
		$finish;
	end

endmodule
